// ----- hdl/rsa_mexp_pkg.sv -----
// Package for the RSA modular exponentiation block.
// Holds port widths, register indexes, reset values and the sequencer state type.
// No dependencies.
package rsa_mexp_pkg;

  localparam int MOD_WIDTH_DEF = 16;
  localparam int EXP_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BYTE_W     = 8;
  localparam int RES_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd2;

  localparam int PUB_EXP_RST  = 3;
  localparam int PRIV_EXP_RST = 1;
  localparam int MODULUS_RST  = 143;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_STEP,
    S_MUL,
    S_SQR,
    S_OUT
  } seq_state_t;

endpackage

// ----- hdl/rsa_modular_exponentiation.sv -----
// RSA modular exponentiation, top level: configuration registers and instances.
// Depends on rsa_mexp_pkg, rsa_mexp_modmul and rsa_mexp_ctrl.
//
// Usage:
//   Input channel (in_valid/in_stall) carries mode and data_byte. Mode 0 raises
//   the byte to public_exponent, mode 1 to private_exponent, modulo modulus.
//   Output channel (out_valid/out_stall) returns one result_value per word.
//   Configuration channel (cfg_valid/cfg_ready) writes register cfg_index:
//   0 public exponent, 1 private exponent, 2 modulus; other indexes are dropped.
//   Write configuration only while no word is in flight.
// Timing:
//   One word at a time; in_stall is high from acceptance until the result is
//   taken. Products come from a bit-serial modular multiplier. A zero
//   modulus returns 0.
// Reset:
//   rst (synchronous) loads exponents 3 and 1 and modulus 143 and idles the
//   sequencer. While a result waits on out_stall it holds; no word is accepted.
module rsa_modular_exponentiation
  import rsa_mexp_pkg::*;
#(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [BYTE_W-1:0]     data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RES_W-1:0]      result_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [EXP_WIDTH-1:0] pub_exp;
  logic [EXP_WIDTH-1:0] priv_exp;
  logic [MOD_WIDTH-1:0] modulus;
  logic                 mm_start;
  logic [MOD_WIDTH-1:0] mm_a;
  logic [MOD_WIDTH-1:0] mm_b;
  logic                 mm_busy;
  logic                 mm_done;
  logic [MOD_WIDTH-1:0] mm_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pub_exp  <= EXP_WIDTH'(PUB_EXP_RST);
      priv_exp <= EXP_WIDTH'(PRIV_EXP_RST);
      modulus  <= MOD_WIDTH'(MODULUS_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PUB_EXP:  pub_exp  <= EXP_WIDTH'(cfg_data);
        REG_PRIV_EXP: priv_exp <= EXP_WIDTH'(cfg_data);
        REG_MODULUS:  modulus  <= MOD_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  rsa_mexp_ctrl #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .pub_exp      (pub_exp),
    .priv_exp     (priv_exp),
    .modulus      (modulus),
    .mm_start     (mm_start),
    .mm_a         (mm_a),
    .mm_b         (mm_b),
    .mm_busy      (mm_busy),
    .mm_done      (mm_done),
    .mm_result    (mm_result)
  );

  rsa_mexp_modmul #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (modulus),
    .busy    (mm_busy),
    .done    (mm_done),
    .result  (mm_result)
  );

endmodule

// ----- hdl/rsa_mexp_modmul.sv -----
// Bit-serial interleaved modular multiplier: r = a * b mod n, one bit of b a cycle.
// Requires a < n (or a = 1) and n >= 1.
// Depends on rsa_mexp_pkg.
module rsa_mexp_modmul
  import rsa_mexp_pkg::*;
#(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] op_a,
  input  logic [MOD_WIDTH-1:0] op_b,
  input  logic [MOD_WIDTH-1:0] modulus,
  output logic                 busy,
  output logic                 done,
  output logic [MOD_WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(MOD_WIDTH);
  localparam int T_W   = MOD_WIDTH + 2;

  logic [MOD_WIDTH-1:0] r;
  logic [MOD_WIDTH-1:0] a_q;
  logic [MOD_WIDTH-1:0] b_q;
  logic [CNT_W-1:0]     cnt;
  logic [T_W-1:0]       t;
  logic [T_W-1:0]       n1;
  logic [T_W-1:0]       n2;
  logic [T_W-1:0]       t_red;
  logic [MOD_WIDTH-1:0] r_next;

  always_comb begin
    n1 = T_W'(modulus);
    n2 = {1'b0, modulus, 1'b0};
    t  = {1'b0, r, 1'b0} + (b_q[MOD_WIDTH-1] ? T_W'(a_q) : '0);
    if (t >= n2) begin
      t_red = t - n2;
    end else if (t >= n1) begin
      t_red = t - n1;
    end else begin
      t_red = t;
    end
    r_next = t_red[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MOD_WIDTH - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= '0;
      a_q <= op_a;
      b_q <= op_b;
    end else if (busy) begin
      r   <= r_next;
      b_q <= {b_q[MOD_WIDTH-2:0], 1'b0};
    end
  end

  assign result = r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("modmul done without a preceding busy cycle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("modmul done while still busy");

endmodule

// ----- hdl/rsa_mexp_ctrl.sv -----
// Square-and-multiply sequencer driving the shared modular multiplier.
// Owns the input and output handshakes, the accumulator, square and exponent.
// Depends on rsa_mexp_pkg.
module rsa_mexp_ctrl
  import rsa_mexp_pkg::*;
#(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [BYTE_W-1:0]    data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RES_W-1:0]     result_value,
  input  logic [EXP_WIDTH-1:0] pub_exp,
  input  logic [EXP_WIDTH-1:0] priv_exp,
  input  logic [MOD_WIDTH-1:0] modulus,
  output logic                 mm_start,
  output logic [MOD_WIDTH-1:0] mm_a,
  output logic [MOD_WIDTH-1:0] mm_b,
  input  logic                 mm_busy,
  input  logic                 mm_done,
  input  logic [MOD_WIDTH-1:0] mm_result
);

  seq_state_t           state;
  seq_state_t           state_next;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] acc_next;
  logic [MOD_WIDTH-1:0] sq;
  logic [MOD_WIDTH-1:0] sq_next;
  logic [EXP_WIDTH-1:0] expo;
  logic [EXP_WIDTH-1:0] expo_next;
  logic                 accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    acc  <= acc_next;
    sq   <= sq_next;
    expo <= expo_next;
  end

  always_comb begin
    state_next = state;
    acc_next   = acc;
    sq_next    = sq;
    expo_next  = expo;
    mm_start   = 1'b0;
    mm_a       = sq;
    mm_b       = sq;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        mm_a     = MOD_WIDTH'(1);
        mm_b     = MOD_WIDTH'(data_byte);
        if (in_valid) begin
          expo_next = mode ? priv_exp : pub_exp;
          if (modulus == '0) begin
            acc_next   = '0;
            state_next = S_OUT;
          end else begin
            acc_next   = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
            mm_start   = 1'b1;
            state_next = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (mm_done) begin
          sq_next    = mm_result;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (expo == '0) begin
          state_next = S_OUT;
        end else if (expo[0]) begin
          mm_a       = acc;
          mm_start   = 1'b1;
          state_next = S_MUL;
        end else begin
          mm_start   = 1'b1;
          state_next = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_done) begin
          acc_next   = mm_result;
          mm_start   = 1'b1;
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          sq_next    = mm_result;
          expo_next  = expo >> 1;
          state_next = S_STEP;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign result_value = RES_W'(acc);

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_busy)
    else $error("multiplier started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accepting a word");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == S_BASE || state == S_MUL || state == S_SQR))
    else $error("multiplier result arrived in an unexpected state");

endmodule

// ----- test/tb_rsa_modular_exponentiation.sv -----
// Testbench for rsa_modular_exponentiation: checks each result against m^e mod n,
// computed in the bench, over directed keys and random keys with random stalls.
// Depends on rsa_mexp_pkg and the rsa_modular_exponentiation RTL.
module tb_rsa_modular_exponentiation;
  timeunit 1ns;
  timeprecision 1ps;
  import rsa_mexp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  mode = MODE_ENCRYPT;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PUB_EXP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  cfg_ready;
  logic [RES_W-1:0]      result_value;

  bit [15:0] key_pub;
  bit [15:0] key_priv;
  bit [15:0] key_mod;
  bit [15:0] pending_results[$];
  bit [15:0] want_result;
  int        mismatches = 0;
  int        results_seen = 0;
  bit        idle_on = 1'b1;

  rsa_modular_exponentiation dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("rsa_modular_exponentiation: mismatch");
    $finish;
  end

  function automatic bit [15:0] modpow_predict(bit [7:0] base, bit [15:0] expo,
                                               bit [15:0] n);
    bit [31:0] acc;
    bit [31:0] sq;
    if (n == 0) return 16'd0;
    acc = 32'd1 % 32'(n);
    sq  = 32'(base) % 32'(n);
    for (int k = 0; k < 16; k++) begin
      if (expo[k]) acc = (acc * sq) % 32'(n);
      sq = (sq * sq) % 32'(n);
    end
    return acc[15:0];
  endfunction

  function automatic bit [15:0] rand_exponent();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'($urandom_range(0, 65535));
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: none expected, got %h", results_seen, result_value);
      end else begin
        want_result = pending_results.pop_front();
        if (result_value !== want_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %h got %h", results_seen, want_result,
                     result_value);
        end
      end
    end
  end

  initial begin
    int run;
    run = 0;
    forever begin
      @(negedge clk);
      if (run > 0) begin
        run--;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall = 1'b1;
        run = $urandom_range(1, 12) - 1;
      end else begin
        out_stall = 1'b0;
        run = $urandom_range(0, 30);
      end
    end
  end

  task automatic send_word(input logic m, input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    mode      = m;
    data_byte = b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(modpow_predict(b, (m == MODE_DECRYPT) ? key_priv : key_pub,
                                             key_mod));
  endtask

  // hold off until the block has returned every word
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PUB_EXP:  key_pub  = value;
      REG_PRIV_EXP: key_priv = value;
      REG_MODULUS:  key_mod  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_phase(input int words);
    int pick;
    wait_drained();
    write_reg(REG_PUB_EXP, rand_exponent());
    write_reg(REG_PRIV_EXP, rand_exponent());
    pick = $urandom_range(0, 9);
    case (pick)
      0: write_reg(REG_MODULUS, 16'd0);
      1: write_reg(REG_MODULUS, 16'd1);
      2: write_reg(REG_MODULUS, 16'd2);
      3: write_reg(REG_MODULUS, 16'hFFFF);
      default: write_reg(REG_MODULUS, 16'($urandom_range(2, 65535)));
    endcase
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    repeat (words) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_reset_keys();
    send_word(MODE_ENCRYPT, 8'hFF);
    send_word(MODE_DECRYPT, 8'hFF);
    send_word(MODE_ENCRYPT, 8'h00);
    send_word(MODE_DECRYPT, 8'd143);
  endtask

  task automatic test_exponent_edges();
    wait_drained();
    write_reg(REG_PUB_EXP, 16'd0);
    write_reg(REG_PRIV_EXP, 16'd1);
    send_word(MODE_ENCRYPT, 8'hA5);
    send_word(MODE_DECRYPT, 8'hA5);
    send_word(MODE_DECRYPT, 8'hFF);
    wait_drained();
    write_reg(REG_PUB_EXP, 16'hFFFF);
    write_reg(REG_PRIV_EXP, 16'hFFFF);
    write_reg(REG_MODULUS, 16'hFFFF);
    send_word(MODE_ENCRYPT, 8'hFF);
    send_word(MODE_DECRYPT, 8'hFE);
  endtask

  task automatic test_modulus_edges();
    wait_drained();
    write_reg(REG_PUB_EXP, 16'd3);
    write_reg(REG_MODULUS, 16'd2);
    send_word(MODE_ENCRYPT, 8'h01);
    send_word(MODE_DECRYPT, 8'hFE);
    wait_drained();
    write_reg(REG_MODULUS, 16'd1);
    send_word(MODE_ENCRYPT, 8'hFF);
    send_word(MODE_DECRYPT, 8'h00);
    wait_drained();
    write_reg(REG_MODULUS, 16'd0);
    send_word(MODE_ENCRYPT, 8'h7F);
    send_word(MODE_DECRYPT, 8'h80);
  endtask

  task automatic test_unused_index();
    wait_drained();
    write_reg(REG_MODULUS, 16'd251);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h0000);
    send_word(MODE_ENCRYPT, 8'hC3);
  endtask

  task automatic test_random_keys();
    idle_on = 1'b1;
    repeat (32) random_phase(50);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (3) random_phase(50);
  endtask

  initial begin
    key_pub  = 16'(PUB_EXP_RST);
    key_priv = 16'(PRIV_EXP_RST);
    key_mod  = 16'(MODULUS_RST);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_keys();
    test_exponent_edges();
    test_modulus_edges();
    test_unused_index();
    test_random_keys();
    test_back_to_back();

    wait_drained();
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("rsa_modular_exponentiation: match");
    end else begin
      $display("rsa_modular_exponentiation: mismatch");
    end
    $finish;
  end

endmodule
